// ===== hdl/smt_pkg.sv =====
// Shared types and constants for the sequence-to-MIDI transcoder.
// No dependencies; imported by every other module of the block.
package smt_pkg;

  // Parser phase of the sequence stream.
  typedef enum logic [1:0] {
    PH_DELTA,
    PH_CMD,
    PH_P1,
    PH_P2
  } phase_t;

  // Kind of event handed from the parser to the emitter.
  typedef enum logic [1:0] {
    EV_MIDI,
    EV_END,
    EV_UNKNOWN
  } ev_kind_t;

  // One queued event: delta bytes, then status and two data bytes (MIDI),
  // or a single flag result (end of track, unknown command).
  typedef struct packed {
    ev_kind_t    kind;
    logic [31:0] delta;
    logic [2:0]  dlen;
    logic [7:0]  status;
    logic [7:0]  d1;
    logic [7:0]  d2;
  } event_t;

  // Item operations
  localparam logic OP_SEQ  = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Sequence command codes
  localparam logic [7:0] CMD_NOP         = 8'd0;
  localparam logic [7:0] CMD_NOTE_OFF    = 8'd1;
  localparam logic [7:0] CMD_END         = 8'd3;
  localparam logic [7:0] CMD_NOTE_ON     = 8'd5;
  localparam logic [7:0] CMD_VOLUME      = 8'd6;
  localparam logic [7:0] CMD_PAN         = 8'd7;
  localparam logic [7:0] CMD_TRACK_START = 8'd9;

  // MIDI status nibbles and controller numbers
  localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
  localparam logic [3:0] NIB_CTRL     = 4'hB;
  localparam logic [7:0] CC_VOLUME    = 8'h07;
  localparam logic [7:0] CC_PAN       = 8'h0A;
  localparam logic [3:0] DRUM_CHANNEL = 4'd9;

  // Delta handling
  localparam logic [7:0] DELTA_END  = 8'h80;
  localparam logic [2:0] DELTA_MAX  = 3'd4;
  localparam logic [2:0] MIDI_BYTES = 3'd3;

  // Event queue depth
  localparam int EVQ_DEPTH = 4;

  // Configuration register indexes
  localparam logic REG_CHANNEL = 1'b0;

  // floor(p * 127 / 255): multiply by constant, divide by 255 through
  // x/255 = (x + (x >> 8) + 1) >> 8, exact for x below 65535.
  function automatic logic [7:0] scale_vol(input logic [7:0] p);
    logic [15:0] prod;
    logic [16:0] sum;
    prod = {8'd0, p} * 16'd127;
    sum  = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

endpackage

// ===== hdl/smt_front.sv =====
// Front end: takes items, parses deltas and commands, owns the volume table.
// Depends on smt_pkg; feeds events into smt_evq.
module smt_front #(
  parameter int INSTRUMENT_SLOTS = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            op_i,
  input  logic [7:0]      byte_i,
  input  logic [7:0]      index_i,
  input  logic [3:0]      channel_i,
  output logic            push_o,
  output smt_pkg::event_t push_ev_o,
  input  logic            q_full_i
);
  import smt_pkg::*;

  localparam int AW = (INSTRUMENT_SLOTS > 1) ? $clog2(INSTRUMENT_SLOTS) : 1;
  localparam logic [8:0] SLOTS9 = 9'(INSTRUMENT_SLOTS);

  phase_t      phase_r, phase_nxt;
  logic [31:0] delta_r, delta_nxt;
  logic [2:0]  dlen_r, dlen_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  fp_r, fp_nxt;

  logic        s1_v_r, s1_v_nxt;
  event_t      s1_ev_r, s1_ev_nxt;
  logic        s1_ts_r, s1_ts_nxt;

  logic [7:0]  mem [INSTRUMENT_SLOTS];
  logic [INSTRUMENT_SLOTS-1:0] vld_r;
  logic [7:0]  rd_data_r;
  logic        rd_ok_r;

  logic        acc, seq;
  logic        ev_v, ev_ts;
  event_t      ev;
  logic [2:0]  dlen_inc;
  logic        wr_ok, rd_in_range;

  assign in_ready_o  = !s1_v_r || !q_full_i;
  assign acc         = in_valid_i && in_ready_o;
  assign seq         = acc && (op_i == OP_SEQ);
  assign dlen_inc    = dlen_r + 3'd1;
  assign wr_ok       = acc && (op_i == OP_LOAD) && ({1'b0, index_i} < SLOTS9);
  assign rd_in_range = {1'b0, byte_i} < SLOTS9;

  // Parse state next value
  always_comb begin
    phase_nxt = phase_r;
    delta_nxt = delta_r;
    dlen_nxt  = dlen_r;
    cmd_nxt   = cmd_r;
    fp_nxt    = fp_r;
    if (seq) begin
      case (phase_r)
        PH_DELTA: begin
          delta_nxt[{dlen_r[1:0], 3'b000} +: 8] = byte_i;
          dlen_nxt = dlen_inc;
          if (byte_i < DELTA_END || dlen_inc >= DELTA_MAX) begin
            phase_nxt = PH_CMD;
          end
        end
        PH_CMD: begin
          cmd_nxt = byte_i;
          if (byte_i == CMD_NOP) begin
            phase_nxt = PH_DELTA;
            delta_nxt = '0;
            dlen_nxt  = '0;
          end else if (byte_i inside {[CMD_NOTE_OFF:CMD_PAN], CMD_TRACK_START}) begin
            phase_nxt = PH_P1;
          end else begin
            // unknown command: the byte opens a fresh delta
            delta_nxt = {24'd0, byte_i};
            dlen_nxt  = 3'd1;
            phase_nxt = (byte_i < DELTA_END) ? PH_CMD : PH_DELTA;
          end
        end
        PH_P1: begin
          if (cmd_r == CMD_NOTE_ON) begin
            fp_nxt    = byte_i;
            phase_nxt = PH_P2;
          end else begin
            phase_nxt = PH_DELTA;
            delta_nxt = '0;
            dlen_nxt  = '0;
          end
        end
        PH_P2: begin
          phase_nxt = PH_DELTA;
          delta_nxt = '0;
          dlen_nxt  = '0;
        end
        default: begin
          phase_nxt = PH_DELTA;
        end
      endcase
    end
  end

  // Event produced by the current item
  always_comb begin
    ev_v      = 1'b0;
    ev_ts     = 1'b0;
    ev.kind   = EV_MIDI;
    ev.delta  = delta_r;
    ev.dlen   = dlen_r;
    ev.status = '0;
    ev.d1     = '0;
    ev.d2     = '0;
    if (seq) begin
      case (phase_r)
        PH_CMD: begin
          if (!(byte_i inside {[CMD_NOP:CMD_PAN], CMD_TRACK_START})) begin
            ev_v    = 1'b1;
            ev.kind = EV_UNKNOWN;
          end
        end
        PH_P1: begin
          case (cmd_r)
            CMD_NOTE_OFF: begin
              ev_v      = 1'b1;
              ev.status = {NIB_NOTE_OFF, channel_i};
              ev.d1     = byte_i;
            end
            CMD_END: begin
              ev_v    = 1'b1;
              ev.kind = EV_END;
            end
            CMD_VOLUME: begin
              ev_v      = 1'b1;
              ev.status = {NIB_CTRL, channel_i};
              ev.d1     = CC_VOLUME;
              ev.d2     = scale_vol(byte_i);
            end
            CMD_PAN: begin
              ev_v      = 1'b1;
              ev.status = {NIB_CTRL, channel_i};
              ev.d1     = CC_PAN;
              ev.d2     = 8'd0 - byte_i;
            end
            CMD_TRACK_START: begin
              if (channel_i != DRUM_CHANNEL) begin
                ev_v      = 1'b1;
                ev_ts     = 1'b1;
                ev.delta  = '0;
                ev.dlen   = 3'd1;
                ev.status = {NIB_CTRL, channel_i};
                ev.d1     = CC_VOLUME;
              end
            end
            default: begin
              ev_v = 1'b0;
            end
          endcase
        end
        PH_P2: begin
          ev_v      = 1'b1;
          ev.status = {NIB_NOTE_ON, channel_i};
          ev.d1     = fp_r;
          ev.d2     = byte_i;
        end
        default: begin
          ev_v = 1'b0;
        end
      endcase
    end
  end

  // Stage register toward the queue; track start picks up the table read here
  always_comb begin
    s1_v_nxt  = s1_v_r;
    s1_ev_nxt = s1_ev_r;
    s1_ts_nxt = s1_ts_r;
    if (acc) begin
      s1_v_nxt  = ev_v;
      s1_ev_nxt = ev;
      s1_ts_nxt = ev_ts;
    end else if (push_o) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_comb begin
    push_o    = s1_v_r && !q_full_i;
    push_ev_o = s1_ev_r;
    if (s1_ts_r) begin
      push_ev_o.d2 = rd_ok_r ? scale_vol(rd_data_r) : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DELTA;
      delta_r <= '0;
      dlen_r  <= '0;
      cmd_r   <= '0;
      fp_r    <= '0;
      s1_v_r  <= 1'b0;
      vld_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      delta_r <= delta_nxt;
      dlen_r  <= dlen_nxt;
      cmd_r   <= cmd_nxt;
      fp_r    <= fp_nxt;
      s1_v_r  <= s1_v_nxt;
      if (wr_ok) begin
        vld_r[index_i[AW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_ev_r <= s1_ev_nxt;
    s1_ts_r <= s1_ts_nxt;
  end

  // Instrument volume table
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[index_i[AW-1:0]] <= byte_i;
    end
    if (acc) begin
      rd_data_r <= mem[byte_i[AW-1:0]];
      rd_ok_r   <= rd_in_range && vld_r[byte_i[AW-1:0]];
    end
  end

endmodule

// ===== hdl/smt_evq.sv =====
// Short event queue between the parser and the byte emitter.
// Depends on smt_pkg.
module smt_evq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_i,
  input  smt_pkg::event_t push_ev_i,
  output logic            full_o,
  input  logic            pop_i,
  output smt_pkg::event_t head_o,
  output logic            empty_o
);
  import smt_pkg::*;

  localparam int PW = $clog2(EVQ_DEPTH);
  localparam logic [PW:0] DEPTH_C = (PW + 1)'(EVQ_DEPTH);

  event_t         q_mem [EVQ_DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [PW:0]    cnt_r, cnt_nxt;

  assign full_o  = (cnt_r == DEPTH_C);
  assign empty_o = (cnt_r == '0);
  assign head_o  = q_mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_i && !pop_i) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_i) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      q_mem[wr_ptr_r] <= push_ev_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o) else $error("event queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !empty_o) else $error("event queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C) else $error("event queue count out of range");

endmodule

// ===== hdl/smt_back.sv =====
// Back end: walks the head event byte by byte into the output register.
// Depends on smt_pkg; reads from smt_evq.
module smt_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty_i,
  input  smt_pkg::event_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic [2:0]      out_flags_o,
  output logic            out_last_o
);
  import smt_pkg::*;

  logic [2:0] idx_r, idx_nxt;
  logic       out_v_r, out_v_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic [2:0] out_flags_r, out_flags_nxt;
  logic       out_last_r, out_last_nxt;

  logic       emit, is_last;
  logic [2:0] total, rel;

  assign emit    = !q_empty_i && (!out_v_r || out_ready_i);
  assign total   = (head_i.kind == EV_MIDI) ? (head_i.dlen + MIDI_BYTES) : 3'd1;
  assign is_last = (idx_r == total - 3'd1);
  assign rel     = idx_r - head_i.dlen;
  assign pop_o   = emit && is_last;

  always_comb begin
    idx_nxt = idx_r;
    if (emit) begin
      idx_nxt = is_last ? 3'd0 : idx_r + 3'd1;
    end
  end

  // flags: {unknown_command, track_end, byte_valid}
  always_comb begin
    out_v_nxt     = out_v_r;
    out_byte_nxt  = out_byte_r;
    out_flags_nxt = out_flags_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_v_nxt    = 1'b1;
      out_last_nxt = is_last;
      case (head_i.kind)
        EV_END: begin
          out_byte_nxt  = 8'd0;
          out_flags_nxt = 3'b010;
        end
        EV_UNKNOWN: begin
          out_byte_nxt  = 8'd0;
          out_flags_nxt = 3'b100;
        end
        default: begin
          out_flags_nxt = 3'b001;
          if (idx_r < head_i.dlen) begin
            out_byte_nxt = head_i.delta[{idx_r[1:0], 3'b000} +: 8];
          end else begin
            case (rel)
              3'd0:    out_byte_nxt = head_i.status;
              3'd1:    out_byte_nxt = head_i.d1;
              default: out_byte_nxt = head_i.d2;
            endcase
          end
        end
      endcase
    end else if (out_ready_i) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r  <= out_byte_nxt;
    out_flags_r <= out_flags_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid_o = out_v_r;
  assign out_byte_o  = out_byte_r;
  assign out_flags_o = out_flags_r;
  assign out_last_o  = out_last_r;

  a_mid_event_held: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != 3'd0 |-> !q_empty_i) else $error("event left queue mid-walk");
  a_flag_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_flags_r[0]) |-> out_last_r) else $error("flag result not last");
  a_flag_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> $onehot(out_flags_r)) else $error("result carries mixed kinds");

endmodule

// ===== hdl/sequence_to_midi_event_transcoder_top.sv =====
// Top level of the sequence-to-MIDI transcoder: config register and wiring.
// Depends on smt_pkg, smt_front, smt_evq and smt_back.
//
// Usage:
//   Input stream: one item per handshake. in_tuser[0] selects the operation
//   (0 = sequence byte, 1 = load an instrument volume slot). in_tdata[7:0]
//   is the sequence byte or the volume, in_tdata[15:8] the slot index.
//   Output stream: one MIDI byte or flag per item. out_tdata is the byte,
//   out_tuser = {unknown_command, track_end, byte_valid}, out_tlast marks the
//   final result caused by one input item.
//   Config port: APB, register 0 at address 0 is the 4-bit MIDI channel.
//   Write it only while the block is idle.
// Timing:
//   The parser takes one item per cycle while in_tready is high. The item's
//   event goes from the parse stage (loaded at the accepting edge) into the
//   event queue and then the output register, where out_tvalid rises. The
//   emitter sends one result per cycle while out_tready is high, up to seven
//   per event; the four-entry queue absorbs the difference between the sides.
// Reset: synchronous, active low; parser back to delta phase, volume table
//   reads as zero everywhere, channel 0, queue and output empty.
// Stall: when out_tready is low the output register holds, the queue fills,
//   and in_tready drops once the parse stage cannot drain into the queue.
module sequence_to_midi_event_transcoder_top #(
  parameter int INSTRUMENT_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [15:8] table_index
  input  logic [0:0]  in_tuser,   // [0] operation
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] midi_byte
  output logic [2:0]  out_tuser,  // [0] byte_valid, [1] track_end, [2] unknown_command
  output logic        out_tlast,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import smt_pkg::*;

  logic [3:0] channel_r, channel_nxt;
  logic       cfg_wr;

  logic       push, pop, q_full, q_empty;
  event_t     push_ev, head_ev;

  // Word address is paddr[2]; only register 0 exists.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_CHANNEL) ? {28'd0, channel_r} : 32'd0;

  always_comb begin
    channel_nxt = channel_r;
    if (cfg_wr && cfg_paddr[2] == REG_CHANNEL) begin
      channel_nxt = cfg_pwdata[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_r <= '0;
    end else begin
      channel_r <= channel_nxt;
    end
  end

  // Parser and volume table
  smt_front #(
    .INSTRUMENT_SLOTS(INSTRUMENT_SLOTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid_i(in_tvalid),
    .in_ready_o(in_tready),
    .op_i      (in_tuser[0]),
    .byte_i    (in_tdata[7:0]),
    .index_i   (in_tdata[15:8]),
    .channel_i (channel_r),
    .push_o    (push),
    .push_ev_o (push_ev),
    .q_full_i  (q_full)
  );

  // Decoupling queue
  smt_evq u_evq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_i   (push),
    .push_ev_i(push_ev),
    .full_o   (q_full),
    .pop_i    (pop),
    .head_o   (head_ev),
    .empty_o  (q_empty)
  );

  // Byte emitter with output register
  smt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty_i  (q_empty),
    .head_i     (head_ev),
    .pop_o      (pop),
    .out_valid_o(out_tvalid),
    .out_ready_i(out_tready),
    .out_byte_o (out_tdata),
    .out_flags_o(out_tuser),
    .out_last_o (out_tlast)
  );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sequence_to_midi_event_transcoder_top: random and directed tracks,
// predicted MIDI bytes compared item by item. Depends on smt_pkg and the block's RTL only.
module testbench;
  import smt_pkg::*;

  localparam int VOL_SLOTS       = 64;
  localparam int ITEMS_PER_PHASE = 105;
  localparam int SETTLE_CYCLES   = 12;   // output sits three stages behind the parser
  localparam int MAX_REPORTS     = 10;
  localparam int CLK_HALF        = 5;
  localparam int RUN_LIMIT_NS    = 2_000_000;

  // codes the block drops without a result; everything else unlisted is unknown
  localparam logic [7:0] CMD_SKIP_A = 8'd2;
  localparam logic [7:0] CMD_SKIP_B = 8'd4;
  localparam logic [7:0] CMD_UNDEF  = 8'd8;
  localparam logic [2:0] CHANNEL_ADDR = {REG_CHANNEL, 2'b00};

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic [7:0] slot;
  } seq_item_t;

  typedef struct packed {
    logic [7:0] midi_byte;
    logic       byte_valid;
    logic       last;
    logic       track_end;
    logic       unknown_cmd;
  } midi_result_t;

  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_HOLD} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;    // [7:0] data_byte, [15:8] table_index
  logic [0:0]  in_tuser = '0;    // [0] operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;        // [7:0] midi_byte
  logic [2:0]  out_tuser;        // [0] byte_valid, [1] track_end, [2] unknown_command
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  sequence_to_midi_event_transcoder_top #(.INSTRUMENT_SLOTS(VOL_SLOTS)) dut (.*);

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: own copy of the parser state, channel and volume table.
  // Updated at the edge an item is accepted, so it follows acceptance order.
  // ---------------------------------------------------------------------------
  phase_t       parse_at;
  logic [31:0]  held_delta;
  logic [2:0]   held_len;
  logic [7:0]   held_cmd;
  logic [7:0]   held_note;
  logic [3:0]   track_channel;
  logic [7:0]   vol_table [0:VOL_SLOTS-1];
  midi_result_t midi_expect[$];   // MIDI bytes and flags still owed by the block
  seq_item_t    pending_items[$]; // items waiting for the sender
  int           items_queued;
  int           fault_count;

  function automatic midi_result_t mk_result(logic [7:0] b, logic v, logic te, logic uc);
    return {b, v, 1'b0, te, uc};
  endfunction

  function automatic logic [7:0] scaled_level(logic [7:0] p);
    int prod;
    prod = int'(p) * 127;
    return 8'(prod / 255);
  endfunction

  function automatic logic is_known_cmd(logic [7:0] b);
    return (b >= CMD_NOTE_OFF && b <= CMD_PAN) || b == CMD_TRACK_START;
  endfunction

  function automatic void restart_delta();
    held_delta = '0;
    held_len   = '0;
    parse_at   = PH_DELTA;
  endfunction

  // a delta closes on a byte below 0x80 or on its fourth byte
  function automatic void take_delta(logic [7:0] b);
    held_delta[8*held_len[1:0] +: 8] = b;
    held_len = held_len + 3'd1;
    if (b < DELTA_END || held_len >= DELTA_MAX) parse_at = PH_CMD;
  endfunction

  function automatic void transcode_item(seq_item_t it);
    midi_result_t res [0:6];
    int           k;
    int           i;
    logic         emit, lead_zero, restart;
    logic [7:0]   status, d1, d2, level;
    k = 0;
    emit = 1'b0;
    lead_zero = 1'b0;
    restart = 1'b0;
    status = '0;
    d1 = '0;
    d2 = '0;
    if (it.op == OP_LOAD) begin
      // loads past the table vanish; parse state is untouched
      if (it.slot < VOL_SLOTS) vol_table[it.slot] = it.data;
      return;
    end
    case (parse_at)
      PH_DELTA: take_delta(it.data);
      PH_CMD: begin
        held_cmd = it.data;
        if (it.data == CMD_NOP) restart_delta();
        else if (is_known_cmd(it.data)) parse_at = PH_P1;
        else begin
          // flag it, drop the held delta, then the same byte opens a new one
          res[k] = mk_result(8'h00, 1'b0, 1'b0, 1'b1);
          k++;
          restart_delta();
          take_delta(it.data);
        end
      end
      PH_P1: begin
        restart = 1'b1;
        case (held_cmd)
          CMD_NOTE_OFF: begin
            emit = 1'b1;
            status = {NIB_NOTE_OFF, track_channel};
            d1 = it.data;
            d2 = 8'h00;
          end
          CMD_END: begin
            res[k] = mk_result(8'h00, 1'b0, 1'b1, 1'b0);
            k++;
          end
          CMD_NOTE_ON: begin
            held_note = it.data;
            parse_at = PH_P2;
            restart = 1'b0;
          end
          CMD_VOLUME: begin
            emit = 1'b1;
            status = {NIB_CTRL, track_channel};
            d1 = CC_VOLUME;
            d2 = scaled_level(it.data);
          end
          CMD_PAN: begin
            emit = 1'b1;
            status = {NIB_CTRL, track_channel};
            d1 = CC_PAN;
            d2 = 8'h00 - it.data;
          end
          CMD_TRACK_START: begin
            // drum channel gets no start volume; others send a zero delta
            if (track_channel != DRUM_CHANNEL) begin
              emit = 1'b1;
              lead_zero = 1'b1;
              status = {NIB_CTRL, track_channel};
              d1 = CC_VOLUME;
              level = (it.data < VOL_SLOTS) ? vol_table[it.data] : 8'h00;
              d2 = scaled_level(level);
            end
          end
          default: ;
        endcase
      end
      default: begin
        emit = 1'b1;
        status = {NIB_NOTE_ON, track_channel};
        d1 = held_note;
        d2 = it.data;
        restart = 1'b1;
      end
    endcase
    if (emit) begin
      if (lead_zero) begin
        res[k] = mk_result(8'h00, 1'b1, 1'b0, 1'b0);
        k++;
      end else begin
        for (i = 0; i < held_len; i++) begin
          res[k] = mk_result(held_delta[8*i +: 8], 1'b1, 1'b0, 1'b0);
          k++;
        end
      end
      res[k] = mk_result(status, 1'b1, 1'b0, 1'b0);
      res[k+1] = mk_result(d1, 1'b1, 1'b0, 1'b0);
      res[k+2] = mk_result(d2, 1'b1, 1'b0, 1'b0);
      k += 3;
    end
    if (restart) restart_delta();
    if (k > 0) res[k-1].last = 1'b1;
    for (i = 0; i < k; i++) midi_expect.push_back(res[i]);
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fault_count++;
      if (fault_count <= MAX_REPORTS)
        $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between them (sometimes none).
  // Each accepted item goes through the predictor at its handshake edge.
  // ---------------------------------------------------------------------------
  seq_item_t sending;
  logic      holding;
  int        burst_left;
  int        gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
      track_channel = '0;
      held_cmd = '0;
      held_note = '0;
      restart_delta();
      foreach (vol_table[i]) vol_table[i] = 8'h00;
    end else begin
      holding = in_tvalid;
      if (in_tvalid && in_tready) begin
        transcode_item(sending);
        holding = 1'b0;
      end
      if (!holding && gap_left > 0) gap_left--;
      else if (!holding && pending_items.size() > 0) begin
        sending = pending_items.pop_front();
        in_tuser <= sending.op;
        in_tdata <= {sending.slot, sending.data};
        holding = 1'b1;
        if (burst_left == 0) burst_left = $urandom_range(1, 24);
        burst_left--;
        if (burst_left == 0)
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
      in_tvalid <= holding;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a mode that is redrawn after each random span:
  // always open, light stalls, heavy stalls, or held off completely.
  // ---------------------------------------------------------------------------
  rx_mode_t rx_mode;
  int       rx_span;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_mode = RX_OPEN;
      rx_span = 0;
    end else begin
      if (rx_span == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_span = $urandom_range(4, 40);
      end
      rx_span--;
      case (rx_mode)
        RX_OPEN:  out_tready <= 1'b1;
        RX_LIGHT: out_tready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY: out_tready <= ($urandom_range(0, 3) == 0);
        default:  out_tready <= 1'b0;
      endcase
    end
  end

  // Checker: every accepted result against the oldest expectation.
  midi_result_t got, want;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata, out_tuser[0], out_tlast, out_tuser[1], out_tuser[2]};
      if (midi_expect.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("%0t result with nothing expected: byte %0h flags %0b last %0b",
                   $realtime, out_tdata, out_tuser, out_tlast);
      end else begin
        want = midi_expect.pop_front();
        check_field("midi_byte", 32'(want.midi_byte), 32'(got.midi_byte));
        check_field("byte_valid", 32'(want.byte_valid), 32'(got.byte_valid));
        check_field("last", 32'(want.last), 32'(got.last));
        check_field("track_end", 32'(want.track_end), 32'(got.track_end));
        check_field("unknown_command", 32'(want.unknown_cmd), 32'(got.unknown_cmd));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_seq(input logic [7:0] b);
    seq_item_t it;
    it.op = OP_SEQ;
    it.data = b;
    it.slot = 8'($urandom_range(0, 255));   // ignored by sequence items
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_load(input logic [7:0] slot, input logic [7:0] vol);
    seq_item_t it;
    it.op = OP_LOAD;
    it.data = vol;
    it.slot = slot;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_random_load();
    logic [7:0] slot;
    slot = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(VOL_SLOTS, 255))
                                       : 8'($urandom_range(0, VOL_SLOTS - 1));
    push_load(slot, 8'($urandom_range(0, 255)));
  endtask

  // sequence byte, now and then with a table load slipped in ahead of it
  task automatic feed_byte(input logic [7:0] b);
    if ($urandom_range(0, 9) == 0) push_random_load();
    push_seq(b);
  endtask

  // one well-formed event: delta of 1..4 bytes, command, its parameters
  task automatic push_random_event();
    int         dlen;
    int         i;
    logic [7:0] cmd;
    dlen = $urandom_range(1, 4);
    for (i = 0; i < dlen - 1; i++) feed_byte(8'($urandom_range(8'h80, 8'hFF)));
    feed_byte((dlen == 4) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 8'h7F)));
    case ($urandom_range(0, 11))
      0:       cmd = CMD_NOP;
      1, 10:   cmd = CMD_NOTE_OFF;
      2:       cmd = CMD_SKIP_A;
      3:       cmd = CMD_END;
      4:       cmd = CMD_SKIP_B;
      5, 6:    cmd = CMD_NOTE_ON;
      7:       cmd = CMD_VOLUME;
      8:       cmd = CMD_PAN;
      9:       cmd = CMD_TRACK_START;
      default: begin
        do cmd = 8'($urandom_range(0, 255)); while (cmd == CMD_NOP || is_known_cmd(cmd));
      end
    endcase
    feed_byte(cmd);
    if (cmd == CMD_TRACK_START)
      feed_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(VOL_SLOTS, 255))
                                             : 8'($urandom_range(0, VOL_SLOTS - 1)));
    else if (cmd == CMD_NOTE_ON) begin
      feed_byte(8'($urandom_range(0, 255)));
      feed_byte(8'($urandom_range(0, 255)));
    end else if (cmd != CMD_NOP && is_known_cmd(cmd) || cmd == CMD_SKIP_A || cmd == CMD_SKIP_B)
      feed_byte(8'($urandom_range(0, 255)));
  endtask

  // mostly clean events, plus loads and stray bytes that break the framing
  task automatic queue_random_track(input int n);
    int target;
    int roll;
    int i;
    target = items_queued + n;
    while (items_queued < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) push_random_event();
      else if (roll < 88) push_random_load();
      else for (i = $urandom_range(1, 3); i > 0; i--) push_seq(8'($urandom_range(0, 255)));
    end
  endtask

  // returns once the sender is empty and every owed result has arrived;
  // sampled mid-cycle so that the edge's updates have all landed.
  // loads and silent commands may still be in flight, hence the settle time
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_tvalid || midi_expect.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of the channel register, then a read back of it
  task automatic write_channel(input logic [3:0] ch);
    logic [31:0] readback;
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= CHANNEL_ADDR;
    cfg_pwdata <= {28'd0, ch};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    track_channel = ch;   // register takes the value at this edge
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    readback = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    check_field("channel readback", {28'd0, ch}, readback);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: directed track on the reset channel, then random tracks on
  // channels 15, 9 (drum), a middle one and 0. Each phase drains fully before
  // the channel changes, which also holds the sender until all results are in.
  // ---------------------------------------------------------------------------
  initial begin
    logic [3:0] phase_channels [0:3];
    phase_channels[0] = 4'd15;
    phase_channels[1] = DRUM_CHANNEL;
    phase_channels[2] = 4'($urandom_range(1, 14));
    phase_channels[3] = 4'd0;
    items_queued = 0;
    fault_count = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // volume table: full scale at the bottom slot, one load past the table
    push_load(8'd0, 8'hFF);
    push_load(8'd63, 8'h80);
    push_load(8'd200, 8'h4D);
    // note-off behind a four-byte delta that never drops below 0x80
    push_seq(8'hFF); push_seq(8'h80); push_seq(8'h80); push_seq(8'h80);
    push_seq(CMD_NOTE_OFF); push_seq(8'h7F);
    // note-on with both parameters at their extremes
    push_seq(8'h00); push_seq(CMD_NOTE_ON); push_seq(8'h00); push_seq(8'hFF);
    // volume at full scale after a two-byte delta
    push_seq(8'h81); push_seq(8'h7F); push_seq(CMD_VOLUME); push_seq(8'hFF);
    // pan of zero wraps to zero
    push_seq(8'h00); push_seq(CMD_PAN); push_seq(8'h00);
    // track start from a loaded slot, then from a slot past the table
    push_seq(8'h05); push_seq(CMD_TRACK_START); push_seq(8'd0);
    push_seq(8'h00); push_seq(CMD_TRACK_START); push_seq(8'd200);
    // dropped commands and end of track
    push_seq(8'h00); push_seq(CMD_NOP);
    push_seq(8'h00); push_seq(CMD_SKIP_B); push_seq(8'h55);
    push_seq(8'h00); push_seq(CMD_END); push_seq(8'hAA);
    // unknown codes: 0xFF reopens an unfinished delta, 8 a finished one
    push_seq(8'h00); push_seq(8'hFF); push_seq(8'h10); push_seq(CMD_UNDEF);
    push_seq(CMD_PAN); push_seq(8'h01);
    wait_drained();

    foreach (phase_channels[p]) begin
      write_channel(phase_channels[p]);
      queue_random_track(ITEMS_PER_PHASE);
      wait_drained();
    end

    if (fault_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #RUN_LIMIT_NS;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
